/* src/segx_pkg.sv */
package segx_pkg;

    localparam int DEPTH = 2;

    typedef struct packed {
        logic early_zero;
        logic side_ok;
    } segx_flags_t;

endpackage

/* src/segx_front.sv */
module segx_front #(
    parameter int CW = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] ax,
    input  logic signed [CW-1:0] ay,
    input  logic signed [CW-1:0] bx,
    input  logic signed [CW-1:0] by_coord,
    input  logic signed [CW-1:0] cx,
    input  logic signed [CW-1:0] cy,
    input  logic signed [CW-1:0] dx,
    input  logic signed [CW-1:0] dy,
    output logic                 q_valid,
    input  logic                 q_ready,
    output segx_pkg::segx_flags_t q_flags,
    output logic signed [CW:0]   q_ux,
    output logic signed [CW:0]   q_uy,
    output logic signed [CW:0]   q_px,
    output logic signed [CW:0]   q_py,
    output logic signed [CW:0]   q_qx,
    output logic signed [CW:0]   q_qy,
    output logic signed [2*CW+2:0] q_cc,
    output logic signed [2*CW+2:0] q_cd
);
    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 3;

    // stage 1: differences and endpoint checks
    logic                 s1_valid_reg;
    logic                 s1_zero_reg;
    logic signed [DW-1:0] ux_reg, uy_reg, px_reg, py_reg, qx_reg, qy_reg;
    // stage 2: cross products
    logic                 s2_valid_reg;
    logic                 s2_zero_reg;
    logic signed [DW-1:0] ux2_reg, uy2_reg, px2_reg, py2_reg, qx2_reg, qy2_reg;
    logic signed [PW-1:0] cc_reg, cd_reg;
    logic                 adv1, adv2, z;

    assign adv2     = !s2_valid_reg || q_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    assign z = (ax == bx && ay == by_coord) || (cx == dx && cy == dy) ||
               (ax == cx && ay == cy) || (bx == cx && by_coord == cy) ||
               (ax == dx && ay == dy) || (bx == dx && by_coord == dy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (adv1) s1_valid_reg <= in_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
        end
        if (adv1) begin
            s1_zero_reg <= z;
            ux_reg <= DW'(bx) - DW'(ax);
            uy_reg <= DW'(by_coord) - DW'(ay);
            px_reg <= DW'(cx) - DW'(ax);
            py_reg <= DW'(cy) - DW'(ay);
            qx_reg <= DW'(dx) - DW'(ax);
            qy_reg <= DW'(dy) - DW'(ay);
        end
        if (adv2) begin
            s2_zero_reg <= s1_zero_reg;
            ux2_reg <= ux_reg; uy2_reg <= uy_reg;
            px2_reg <= px_reg; py2_reg <= py_reg;
            qx2_reg <= qx_reg; qy2_reg <= qy_reg;
            cc_reg <= PW'(py_reg) * PW'(ux_reg) - PW'(px_reg) * PW'(uy_reg);
            cd_reg <= PW'(qy_reg) * PW'(ux_reg) - PW'(qx_reg) * PW'(uy_reg);
        end
    end

    assign q_valid = s2_valid_reg;
    assign q_flags.early_zero = s2_zero_reg;
    assign q_flags.side_ok = cc_reg[PW-1] != cd_reg[PW-1];
    assign q_ux = ux2_reg; assign q_uy = uy2_reg;
    assign q_px = px2_reg; assign q_py = py2_reg;
    assign q_qx = qx2_reg; assign q_qy = qy2_reg;
    assign q_cc = cc_reg;  assign q_cd = cd_reg;
endmodule

/* src/segx_queue.sv */
module segx_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    localparam int D = segx_pkg::DEPTH;
    logic [W-1:0] mem_reg [D];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         wr, rd;

    assign wr_ready = cnt_reg != 2'(D);
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule

/* src/segx_back.sv */
module segx_back #(
    parameter int CW = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  segx_pkg::segx_flags_t  q_flags,
    input  logic signed [CW:0]     q_ux,
    input  logic signed [CW:0]     q_uy,
    input  logic signed [CW:0]     q_px,
    input  logic signed [CW:0]     q_py,
    input  logic signed [CW:0]     q_qx,
    input  logic signed [CW:0]     q_qy,
    input  logic signed [2*CW+2:0] q_cc,
    input  logic signed [2*CW+2:0] q_cd,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit
);
    localparam int PW = 2 * CW + 3;
    localparam int XW = 2 * CW + 4;
    localparam int LO = XW / 2;
    localparam int HI = XW - LO;
    localparam int MW = LO + 1 + HI;
    localparam int NW = 2 * XW;

    // b1: dot products, length, sign-normalized cross products and denominator
    logic                 b1_valid_reg, b1_live_reg;
    logic signed [PW-1:0] dc_reg, dd_reg;
    logic signed [XW-1:0] cc1_reg, cd1_reg, den_reg, len_reg;
    // b2: split partial products
    logic                 b2_valid_reg, b2_live_reg;
    logic [2*LO-1:0]      ll_reg [3];
    logic signed [MW-1:0] lh_reg [3];
    logic signed [MW-1:0] hl_reg [3];
    logic signed [2*HI-1:0] hh_reg [3];
    // b3: full products
    logic                 b3_valid_reg, b3_live_reg;
    logic signed [NW-1:0] prod_reg [3];
    logic                 out_valid_reg, hit_reg;
    logic                 adv1, adv2, adv3, adv4;
    logic signed [XW-1:0] den_c, cc_c, cd_c;
    logic signed [XW-1:0] op_a [3];
    logic signed [XW-1:0] op_b [3];
    logic signed [NW-1:0] num_c;

    assign adv4    = !out_valid_reg || m_ready;
    assign adv3    = !b3_valid_reg || adv4;
    assign adv2    = !b2_valid_reg || adv3;
    assign adv1    = !b1_valid_reg || adv2;
    assign q_ready = adv1;

    // a negative denominator flips the sign of both cross products
    always_comb begin
        den_c = XW'(q_cd) - XW'(q_cc);
        cc_c  = XW'(q_cc);
        cd_c  = XW'(q_cd);
        if (den_c[XW-1]) begin
            den_c = -den_c;
            cc_c  = -cc_c;
            cd_c  = -cd_c;
        end
    end

    assign op_a[0] = XW'(dc_reg);
    assign op_b[0] = cd1_reg;
    assign op_a[1] = XW'(dd_reg);
    assign op_b[1] = cc1_reg;
    assign op_a[2] = den_reg;
    assign op_b[2] = len_reg;

    assign num_c = prod_reg[0] - prod_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0; b2_valid_reg <= 1'b0; b3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv1) b1_valid_reg <= q_valid;
            if (adv2) b2_valid_reg <= b1_valid_reg;
            if (adv3) b3_valid_reg <= b2_valid_reg;
            if (adv4) out_valid_reg <= b3_valid_reg;
        end
        if (adv1) begin
            b1_live_reg <= !q_flags.early_zero && q_flags.side_ok;
            dc_reg  <= PW'(q_px) * PW'(q_ux) + PW'(q_py) * PW'(q_uy);
            dd_reg  <= PW'(q_qx) * PW'(q_ux) + PW'(q_qy) * PW'(q_uy);
            len_reg <= XW'(q_ux) * XW'(q_ux) + XW'(q_uy) * XW'(q_uy);
            cc1_reg <= cc_c;
            cd1_reg <= cd_c;
            den_reg <= den_c;
        end
        if (adv2) begin
            b2_live_reg <= b1_live_reg;
            for (int k = 0; k < 3; k++) begin
                ll_reg[k] <= op_a[k][LO-1:0] * op_b[k][LO-1:0];
                lh_reg[k] <= $signed({1'b0, op_a[k][LO-1:0]}) * $signed(op_b[k][XW-1:LO]);
                hl_reg[k] <= $signed(op_a[k][XW-1:LO]) * $signed({1'b0, op_b[k][LO-1:0]});
                hh_reg[k] <= $signed(op_a[k][XW-1:LO]) * $signed(op_b[k][XW-1:LO]);
            end
        end
        if (adv3) begin
            b3_live_reg <= b2_live_reg;
            for (int k = 0; k < 3; k++)
                prod_reg[k] <= (NW'(hh_reg[k]) <<< (2 * LO)) +
                               ((NW'(lh_reg[k]) + NW'(hl_reg[k])) <<< LO) +
                               NW'(ll_reg[k]);
        end
        if (adv4)
            hit_reg <= b3_live_reg && !num_c[NW-1] && (num_c <= prod_reg[2]);
    end

    assign m_valid = out_valid_reg;
    assign m_hit   = hit_reg;
endmodule

/* src/segment_intersection_test.sv */
// channel | ports                          | accepted when
// input   | s_valid s_ready s_ax..s_dy     | s_valid && s_ready
// result  | m_valid m_ready m_hit          | m_valid && m_ready
// One transaction per cycle sustained while m_ready stays high; the path to m_valid runs
// through 2 front stages, a 2-entry decoupling queue and 4 back stages.
// The front pipe computes differences, endpoint checks and cross products; the
// back pipe dot products, length, denominator, split wide products and hit test.
// aresetn is synchronous, active low, and empties every stage.
// Any stage holds when the next cannot take it; m_ready low stalls back to front.
module segment_intersection_test #(
    parameter int COORD_FRAC_BITS = 8,
    parameter int COORD_WIDTH     = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_ax,
    input  logic signed [COORD_WIDTH-1:0] s_ay,
    input  logic signed [COORD_WIDTH-1:0] s_bx,
    input  logic signed [COORD_WIDTH-1:0] s_by_coord,
    input  logic signed [COORD_WIDTH-1:0] s_cx,
    input  logic signed [COORD_WIDTH-1:0] s_cy,
    input  logic signed [COORD_WIDTH-1:0] s_dx,
    input  logic signed [COORD_WIDTH-1:0] s_dy,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit
);
    localparam int CW = COORD_WIDTH + 0 * COORD_FRAC_BITS;
    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 3;
    localparam int QW = 2 + 6 * DW + 2 * PW;

    logic                  f_valid, f_ready, b_valid, b_ready;
    segx_pkg::segx_flags_t f_flags, b_flags;
    logic signed [DW-1:0]  f_ux, f_uy, f_px, f_py, f_qx, f_qy;
    logic signed [DW-1:0]  b_ux, b_uy, b_px, b_py, b_qx, b_qy;
    logic signed [PW-1:0]  f_cc, f_cd, b_cc, b_cd;
    logic [QW-1:0]         wdata, rdata;

    segx_front #(.CW(CW)) u_front (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .ax(s_ax), .ay(s_ay), .bx(s_bx), .by_coord(s_by_coord),
        .cx(s_cx), .cy(s_cy), .dx(s_dx), .dy(s_dy),
        .q_valid(f_valid), .q_ready(f_ready), .q_flags(f_flags),
        .q_ux(f_ux), .q_uy(f_uy), .q_px(f_px), .q_py(f_py),
        .q_qx(f_qx), .q_qy(f_qy), .q_cc(f_cc), .q_cd(f_cd)
    );

    assign wdata = {f_flags, f_ux, f_uy, f_px, f_py, f_qx, f_qy, f_cc, f_cd};
    assign {b_flags, b_ux, b_uy, b_px, b_py, b_qx, b_qy, b_cc, b_cd} = rdata;

    segx_queue #(.W(QW)) u_queue (
        .aclk, .aresetn, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(wdata),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(rdata)
    );

    segx_back #(.CW(CW)) u_back (
        .aclk, .aresetn, .q_valid(b_valid), .q_ready(b_ready), .q_flags(b_flags),
        .q_ux(b_ux), .q_uy(b_uy), .q_px(b_px), .q_py(b_py),
        .q_qx(b_qx), .q_qy(b_qy), .q_cc(b_cc), .q_cd(b_cd),
        .m_valid, .m_ready, .m_hit
    );
endmodule

/* sim/segx_checker.sv */
`timescale 1ns / 1ps

module segx_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic signed [19:0]  s_ax,
    input  logic signed [19:0]  s_ay,
    input  logic signed [19:0]  s_bx,
    input  logic signed [19:0]  s_by_coord,
    input  logic signed [19:0]  s_cx,
    input  logic signed [19:0]  s_cy,
    input  logic signed [19:0]  s_dx,
    input  logic signed [19:0]  s_dy,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_hit,
    output int                  errors,
    output int                  pending
);

    bit expected_hits[$];

    function automatic bit crosses(
        input logic signed [19:0] ax, ay, bx, by, cx, cy, dx, dy
    );
        logic signed [63:0]  ux, uy, px, py, qx, qy, cc, cd, dc, dd, den, len2;
        logic signed [127:0] num, lim;
        if ((ax == bx && ay == by) || (cx == dx && cy == dy)) return 1'b0;
        if ((ax == cx && ay == cy) || (bx == cx && by == cy) ||
            (ax == dx && ay == dy) || (bx == dx && by == dy)) return 1'b0;
        ux = bx - ax; uy = by - ay;
        px = cx - ax; py = cy - ay;
        qx = dx - ax; qy = dy - ay;
        cc = py * ux - px * uy;
        cd = qy * ux - qx * uy;
        if ((cc < 0) == (cd < 0)) return 1'b0;
        dc = px * ux + py * uy;
        dd = qx * ux + qy * uy;
        len2 = ux * ux + uy * uy;
        den = cd - cc;
        num = 128'(dc) * 128'(cd) - 128'(dd) * 128'(cc);
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        lim = 128'(den) * 128'(len2);
        return (num >= 0) && (num <= lim);
    endfunction

    assign pending = expected_hits.size();

    always @(posedge aclk) begin
        bit exp_hit;
        if (!aresetn) begin
            errors <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_hits.push_back(crosses(s_ax, s_ay, s_bx, s_by_coord,
                                                s_cx, s_cy, s_dx, s_dy));
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    $error("hit: unexpected transaction, actual %0d", m_hit);
                    errors <= errors + 1;
                end else begin
                    exp_hit = expected_hits.pop_front();
                    if (m_hit !== exp_hit) begin
                        $error("hit: expected %0d actual %0d", exp_hit, m_hit);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_RANDOM = 1130;

    logic aclk, aresetn, s_valid, s_ready, m_valid, m_ready, m_hit;
    logic signed [19:0] s_ax, s_ay, s_bx, s_by_coord, s_cx, s_cy, s_dx, s_dy;
    int errors, pending, idle_cycles, send_idle_pct, recv_stall_pct;
    bit timed_out;

    segment_intersection_test u_dut (.*);

    segx_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("** segment_intersection_test: FAILED **");
            $finish;
        end
    end

    task automatic send_segments(input logic signed [19:0] ax, ay, bx, by, cx, cy, dx, dy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_ax <= ax; s_ay <= ay; s_bx <= bx; s_by_coord <= by;
        s_cx <= cx; s_cy <= cy; s_dx <= dx; s_dy <= dy;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic signed [19:0] pick_coord(input int span);
        case ($urandom_range(5))
            0: return 20'sh80000;
            1: return 20'sh7ffff;
            2: return 20'($urandom);
            default: return 20'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    task automatic random_item();
        logic signed [19:0] ax, ay, bx, by, cx, cy, dx, dy;
        int span;
        span = ($urandom_range(3) == 0) ? 16 : 2000;
        ax = pick_coord(span); ay = pick_coord(span);
        bx = pick_coord(span); by = pick_coord(span);
        cx = pick_coord(span); cy = pick_coord(span);
        dx = pick_coord(span); dy = pick_coord(span);
        case ($urandom_range(9))
            0: begin cx = ax; cy = ay; end
            1: begin bx = ax; by = ay; end
            2: begin dx = cx; dy = cy; end
            3: begin
                cx = ax + (bx - ax) / 2; cy = ay + (by - ay) / 2;
            end
            default: ;
        endcase
        send_segments(ax, ay, bx, by, cx, cy, dx, dy);
    endtask

    initial begin
        s_valid = 1'b0;
        {s_ax, s_ay, s_bx, s_by_coord, s_cx, s_cy, s_dx, s_dy} = '0;
        m_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        timed_out = 1'b0;
        idle_cycles = 0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_segments(0, 0, 256, 256, 0, 256, 256, 0);
        send_segments(0, 0, 256, 0, 0, -256, 0, 256);
        send_segments(0, 0, 256, 0, 256, -256, 256, 256);
        send_segments(0, 0, 256, 0, 257, -256, 257, 256);
        send_segments(0, 0, 256, 0, 128, 0, 128, 256);
        send_segments(0, 0, 256, 0, 128, 0, 128, -256);
        send_segments(0, 0, 256, 0, 128, 256, 128, 0);
        send_segments(5, 5, 5, 5, 0, -9, 0, 9);
        send_segments(0, 0, 256, 0, 7, 7, 7, 7);
        send_segments(0, 0, 256, 0, 0, 0, 9, 9);
        send_segments(0, 0, 256, 0, 256, 0, 9, 9);
        send_segments(0, 0, 256, 0, 3, 3, 0, 0);
        send_segments(0, 0, 256, 0, 3, 3, 256, 0);
        send_segments(0, 0, 256, 0, 10, 5, 20, 5);
        send_segments(0, 0, 256, 0, 10, -5, 20, -5);
        send_segments(-524288, -524288, 524287, 524287, -524288, 524287,
                      524287, -524288);
        send_segments(524287, -524288, -524288, 524287, -524288, -524288,
                      524287, 524287);
        send_segments(-524288, 0, 524287, 0, 0, -524288, 0, 524287);
        send_segments(-524288, -524288, -524288, 524287, 524287, 0, -524288, 0);
        send_segments(0, 0, 256, 0, 300, -5, 300, 5);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 3 ? 12 : 57) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 12 : 57) : 0;
            repeat (N_RANDOM / 4) random_item();
        end
        s_valid <= 1'b0;
        recv_stall_pct = 0;

        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("** segment_intersection_test: PASSED **");
        else
            $display("** segment_intersection_test: FAILED **");
        $finish;
    end

endmodule
